[rtl/colst_pkg.sv]
// Shared constants and types for the column statistics block.
package colst_pkg;

    localparam int SAMPLE_W = 32;
    localparam int SUM_W    = 42;
    localparam int ALU_W    = SUM_W + 1;
    localparam int ROW_W    = 11;
    localparam int IDX_W    = 10;
    localparam int TOL_W    = 16;
    localparam int REM_W    = ROW_W + 1;
    localparam int CNT_W    = 6;
    localparam int MAX_ROWS = 1024;
    localparam int ADDR_W   = 3;
    localparam int DATA_W   = 32;

    // register index, taken from paddr[2]
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_TOLERANCE = 1'b1;

    // request to the shared add/subtract unit
    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic             sub;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             neg;
    } t_alu_rsp;

endpackage

[rtl/colst_in_if.sv]
// Sample channel: valid/ready handshake carrying one Q16.16 sample.
interface colst_in_if import colst_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[rtl/colst_out_if.sv]
// Result channel: valid/ready handshake carrying one column summary.
interface colst_out_if import colst_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] col_max;
    logic signed [SAMPLE_W-1:0] col_min;
    logic signed [SAMPLE_W-1:0] col_mean;
    logic signed [SAMPLE_W-1:0] col_median;
    logic                       is_sorted;

    modport source (output valid, output col_max, output col_min, output col_mean,
                    output col_median, output is_sorted, input ready);
    modport sink   (input valid, input col_max, input col_min, input col_mean,
                    input col_median, input is_sorted, output ready);
endinterface

[rtl/colst_alu.sv]
// Shared add/subtract unit used by every step of the column sequencer.
module colst_alu import colst_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W-1:0] res;

    assign b_eff = i_req.b ^ {ALU_W{i_req.sub}};
    assign res   = i_req.a + b_eff + {{(ALU_W-1){1'b0}}, i_req.sub};

    always_comb begin
        o_rsp.res = res;
        o_rsp.neg = res[ALU_W-1];
    end

endmodule

[rtl/column_statistics.sv]
// Top level of the column statistics block: sequencer, state and config registers.
//
// Usage:
//   Samples (signed Q16.16) arrive on i_in, one per transaction. After
//   row_count samples the block emits one transaction on o_out carrying the
//   column max, min, mean (sum / row_count, truncated toward zero), the
//   median (floor of the mean of the middle samples, 0 when unsorted) and
//   the sortedness flag. Then a fresh column starts.
//   Config goes over the APB port: row_count at 0x0, sorted_tolerance at
//   0x4. Writes take effect at once; pready is tied high.
// Timing:
//   All arithmetic runs through one shared 43-bit add/subtract unit, one
//   step per cycle. A sample is accepted and then passes through five steps
//   (max, min, sum, difference, tolerance); i_in.ready is low meanwhile.
//   The last sample of a column adds a 42-step restoring division of the
//   sum by the row count, plus abs, negate and median steps.
// Reset / stall:
//   Synchronous active-low reset clears the column, sets row_count to 1 and
//   tolerance to 0. The result sits in an output register; the next column's
//   samples are accepted while it waits, and only the next column's result
//   holds in its final step until the receiver takes the pending one.
module column_statistics import colst_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    colst_in_if.sink            i_in,
    colst_out_if.source         o_out,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [ADDR_W-1:0]   paddr,
    input  logic [DATA_W-1:0]   pwdata,
    output logic [DATA_W-1:0]   prdata,
    output logic                pready
);

    typedef enum logic [3:0] {
        S_IDLE, S_MAX, S_MIN, S_SUM, S_DIFF, S_SORT, S_ABS, S_DIV, S_NEG, S_MED, S_DONE
    } t_state;

    t_state                      r_state;
    logic [ROW_W-1:0]            r_row_count;
    logic [TOL_W-1:0]            r_tol;
    logic [IDX_W-1:0]            r_idx;
    logic [SAMPLE_W-1:0]         r_x;
    logic [SAMPLE_W-1:0]         r_max;
    logic [SAMPLE_W-1:0]         r_min;
    logic [SUM_W-1:0]            r_sum;
    logic [SAMPLE_W-1:0]         r_prev;
    logic                        r_sorted;
    logic [SAMPLE_W-1:0]         r_mid_lo;
    logic [SAMPLE_W-1:0]         r_mid_hi;
    logic [ALU_W-1:0]            r_acc;
    logic [SUM_W-1:0]            r_quo;
    logic [REM_W-1:0]            r_rem;
    logic [CNT_W-1:0]            r_cnt;
    logic                        r_out_valid;
    logic [SAMPLE_W-1:0]         r_out_max;
    logic [SAMPLE_W-1:0]         r_out_min;
    logic [SAMPLE_W-1:0]         r_out_mean;
    logic [SAMPLE_W-1:0]         r_out_median;
    logic                        r_out_sorted;

    logic [ROW_W-1:0]            eff_rows;
    logic [ROW_W-1:0]            lo_idx;
    logic [ROW_W-1:0]            hi_idx;
    logic                        last_sample;
    logic [REM_W-1:0]            rem_sh;
    logic                        cfg_wr;
    t_alu_req                    alu_req;
    t_alu_rsp                    alu_rsp;

    function automatic logic [ALU_W-1:0] sx(input logic [SAMPLE_W-1:0] v);
        sx = {{(ALU_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // effective count: zero reads as one, large values clip to the max
    always_comb begin
        if (r_row_count == '0) begin
            eff_rows = ROW_W'(1);
        end else if (r_row_count > ROW_W'(MAX_ROWS)) begin
            eff_rows = ROW_W'(MAX_ROWS);
        end else begin
            eff_rows = r_row_count;
        end
    end

    assign lo_idx      = (eff_rows - ROW_W'(1)) >> 1;
    assign hi_idx      = eff_rows >> 1;
    assign last_sample = ({1'b0, r_idx} + ROW_W'(1)) >= eff_rows;
    assign rem_sh      = {r_rem[REM_W-2:0], r_quo[SUM_W-1]};

    // operand select for the shared unit
    always_comb begin
        alu_req.a   = '0;
        alu_req.b   = '0;
        alu_req.sub = 1'b0;
        case (r_state)
            S_MAX: begin
                alu_req.a   = sx(r_max);
                alu_req.b   = sx(r_x);
                alu_req.sub = 1'b1;              // negative: new sample above max
            end
            S_MIN: begin
                alu_req.a   = sx(r_x);
                alu_req.b   = sx(r_min);
                alu_req.sub = 1'b1;              // negative: new sample below min
            end
            S_SUM: begin
                alu_req.a   = {r_sum[SUM_W-1], r_sum};
                alu_req.b   = sx(r_x);
            end
            S_DIFF: begin
                alu_req.a   = sx(r_prev);
                alu_req.b   = sx(r_x);
                alu_req.sub = 1'b1;
            end
            S_SORT: begin
                alu_req.a   = {{(ALU_W-TOL_W){1'b0}}, r_tol};
                alu_req.b   = r_acc;
                alu_req.sub = 1'b1;              // negative: descent beyond tolerance
            end
            S_ABS: begin
                alu_req.b   = {r_sum[SUM_W-1], r_sum};
                alu_req.sub = r_sum[SUM_W-1];
            end
            S_DIV: begin
                alu_req.a   = {{(ALU_W-REM_W){1'b0}}, rem_sh};
                alu_req.b   = {{(ALU_W-ROW_W){1'b0}}, eff_rows};
                alu_req.sub = 1'b1;
            end
            S_NEG: begin
                alu_req.b   = {1'b0, r_quo};
                alu_req.sub = r_sum[SUM_W-1];
            end
            S_MED: begin
                alu_req.a   = sx(r_mid_lo);
                alu_req.b   = sx(r_mid_hi);
            end
            default: begin
                alu_req.sub = 1'b0;
            end
        endcase
    end

    colst_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_row_count <= ROW_W'(1);
            r_tol       <= '0;
            r_idx       <= '0;
            r_max       <= '0;
            r_min       <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
            r_sorted    <= 1'b1;
            r_mid_lo    <= '0;
            r_mid_hi    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_ROW_COUNT: r_row_count <= pwdata[ROW_W-1:0];
                    REG_TOLERANCE: r_tol       <= pwdata[TOL_W-1:0];
                endcase
            end

            // S_DONE reloads the output register itself on a handshake
            if (o_out.valid && o_out.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_x     <= i_in.sample;
                        r_state <= S_MAX;
                    end
                end
                S_MAX: begin
                    if (r_idx == '0 || alu_rsp.neg) begin
                        r_max <= r_x;
                    end
                    r_state <= S_MIN;
                end
                S_MIN: begin
                    if (r_idx == '0 || alu_rsp.neg) begin
                        r_min <= r_x;
                    end
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_idx == '0) begin
                        r_sum <= {{(SUM_W-SAMPLE_W){r_x[SAMPLE_W-1]}}, r_x};
                    end else begin
                        r_sum <= alu_rsp.res[SUM_W-1:0];
                    end
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_acc   <= alu_rsp.res;
                    r_state <= S_SORT;
                end
                S_SORT: begin
                    if (r_idx != '0 && alu_rsp.neg) begin
                        r_sorted <= 1'b0;
                    end
                    r_prev <= r_x;
                    if ({1'b0, r_idx} == lo_idx) begin
                        r_mid_lo <= r_x;
                    end
                    if ({1'b0, r_idx} == hi_idx) begin
                        r_mid_hi <= r_x;
                    end
                    if (last_sample) begin
                        r_state <= S_ABS;
                    end else begin
                        r_idx   <= r_idx + IDX_W'(1);
                        r_state <= S_IDLE;
                    end
                end
                S_ABS: begin
                    r_quo   <= alu_rsp.res[SUM_W-1:0];
                    r_rem   <= '0;
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (alu_rsp.neg) begin
                        r_rem <= rem_sh;
                    end else begin
                        r_rem <= alu_rsp.res[REM_W-1:0];
                    end
                    r_quo <= {r_quo[SUM_W-2:0], ~alu_rsp.neg};
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(SUM_W - 1)) begin
                        r_state <= S_NEG;
                    end
                end
                S_NEG: begin
                    r_quo   <= alu_rsp.res[SUM_W-1:0];
                    r_state <= S_MED;
                end
                S_MED: begin
                    r_acc   <= alu_rsp.res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_max    <= r_max;
                        r_out_min    <= r_min;
                        r_out_mean   <= r_quo[SAMPLE_W-1:0];
                        r_out_median <= r_sorted ? r_acc[SAMPLE_W:1] : '0;
                        r_out_sorted <= r_sorted;
                        // start a fresh column
                        r_idx    <= '0;
                        r_max    <= '0;
                        r_min    <= '0;
                        r_sum    <= '0;
                        r_prev   <= '0;
                        r_sorted <= 1'b1;
                        r_mid_lo <= '0;
                        r_mid_hi <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready       = (r_state == S_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.col_max    = r_out_max;
    assign o_out.col_min    = r_out_min;
    assign o_out.col_mean   = r_out_mean;
    assign o_out.col_median = r_out_median;
    assign o_out.is_sorted  = r_out_sorted;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TOLERANCE) ? {{(DATA_W-TOL_W){1'b0}}, r_tol}
                                                : {{(DATA_W-ROW_W){1'b0}}, r_row_count};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("sample accepted while sequencer still busy");

    a_div_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_cnt < CNT_W'(SUM_W))
        else $error("division ran past the quotient width");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < {1'b0, eff_rows})
        else $error("partial remainder not below the divisor");

    a_unsorted_median: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.is_sorted |-> o_out.col_median == '0)
        else $error("nonzero median on an unsorted column");
`endif

endmodule
